// File: rtl/core/tsf_pkg.sv
// ----------------------------------------------------------------------------
// tsf_pkg
// Shared types, constants and saturating arithmetic for the trend smoothing
// filter.
// ----------------------------------------------------------------------------
package tsf_pkg;

  localparam int unsigned RegCount = 8;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned WeightW  = 8;
  localparam int unsigned SumW     = 9;
  localparam int unsigned PriceW   = 24;
  localparam int unsigned FieldW   = 32;
  localparam int unsigned WideW    = 64;
  localparam int unsigned ProdW    = 74;

  // register indexes
  localparam logic [RegIdxW-1:0] RegLevelInput  = 3'd0;
  localparam logic [RegIdxW-1:0] RegLevelHist   = 3'd1;
  localparam logic [RegIdxW-1:0] RegSlopeInput  = 3'd2;
  localparam logic [RegIdxW-1:0] RegSlopeHist   = 3'd3;
  localparam logic [RegIdxW-1:0] RegLevelHold   = 3'd4;
  localparam logic [RegIdxW-1:0] RegLevelTrend  = 3'd5;
  localparam logic [RegIdxW-1:0] RegSlopeHold   = 3'd6;
  localparam logic [RegIdxW-1:0] RegSlopeTrend  = 3'd7;

  typedef logic [WeightW-1:0] weight_arr_t [RegCount];
  localparam weight_arr_t WeightReset = '{8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd0, 8'd1, 8'd0};

  localparam logic signed [WideW-1:0] NoSlopeRatio = 64'sd100000000;
  localparam logic [SumW-1:0]         TrendGain    = 9'd2;
  localparam logic signed [WideW-1:0] Max64        = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [WideW-1:0] Min64        = 64'sh8000_0000_0000_0000;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_FIRST,
    CMD_LSETUP,
    CMD_SSETUP,
    CMD_BYPASS,
    CMD_E1,
    CMD_E2,
    CMD_E3,
    CMD_T1,
    CMD_T2,
    CMD_T3,
    CMD_TDIV,
    CMD_TQ,
    CMD_U1,
    CMD_U2,
    CMD_UDIV,
    CMD_UQ,
    CMD_STAGE_DONE,
    CMD_RATIO,
    CMD_RQ,
    CMD_COMMIT
  } cmd_e;

  typedef struct packed {
    cmd_e step;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic stage_bad;
    logic stage_slope;
    logic skip_slope;
    logic ratio_direct;
    logic div_done;
    logic out_free;
  } status_t;

  function automatic logic signed [WideW-1:0] sat64(input logic signed [ProdW-1:0] v);
    logic signed [ProdW-1:0] hi;
    logic signed [ProdW-1:0] lo;
    hi = ProdW'(Max64);
    lo = ProdW'(Min64);
    if (v > hi) begin
      return Max64;
    end else if (v < lo) begin
      return Min64;
    end
    return v[WideW-1:0];
  endfunction

  function automatic logic signed [WideW-1:0] sat_mul(input logic signed [WideW-1:0] v,
                                                      input logic [SumW-1:0] w);
    logic signed [ProdW-1:0] p;
    p = ProdW'(v) * ProdW'($signed({1'b0, w}));
    return sat64(p);
  endfunction

  function automatic logic signed [WideW-1:0] sat_add(input logic signed [WideW-1:0] a,
                                                      input logic signed [WideW-1:0] b);
    logic signed [ProdW-1:0] s;
    s = ProdW'(a) + ProdW'(b);
    return sat64(s);
  endfunction

  function automatic logic signed [WideW-1:0] sat_sub(input logic signed [WideW-1:0] a,
                                                      input logic signed [WideW-1:0] b);
    logic signed [ProdW-1:0] s;
    s = ProdW'(a) - ProdW'(b);
    return sat64(s);
  endfunction

endpackage

// File: rtl/core/tsf_sample_if.sv
// ----------------------------------------------------------------------------
// tsf_sample_if
// Request channel carrying one price sample.
// ----------------------------------------------------------------------------
interface tsf_sample_if;
  logic                         valid;
  logic                         ready;
  logic [tsf_pkg::PriceW-1:0]   price;
  logic                         series_start;

  modport source (output valid, price, series_start, input ready);
  modport sink   (input valid, price, series_start, output ready);
endinterface

// File: rtl/core/tsf_result_if.sv
// ----------------------------------------------------------------------------
// tsf_result_if
// Request channel carrying one filter result.
// ----------------------------------------------------------------------------
interface tsf_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [tsf_pkg::FieldW-1:0]  level;
  logic signed [tsf_pkg::FieldW-1:0]  slope;
  logic signed [tsf_pkg::FieldW-1:0]  smoothed_slope;
  logic signed [tsf_pkg::FieldW-1:0]  ratio;
  logic                               bad_config;

  modport source (output valid, level, slope, smoothed_slope, ratio, bad_config, input ready);
  modport sink   (input valid, level, slope, smoothed_slope, ratio, bad_config, output ready);
endinterface

// File: rtl/core/tsf_cfg_if.sv
// ----------------------------------------------------------------------------
// tsf_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface tsf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tsf_pkg::CfgIdxW-1:0]   index;
  logic [tsf_pkg::WeightW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/tsf_div.sv
// ----------------------------------------------------------------------------
// tsf_div
// Signed 64-bit restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module tsf_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [tsf_pkg::WideW-1:0]    dividend_i,
  input  logic signed [tsf_pkg::WideW-1:0]    divisor_i,
  output logic                                done_o,
  output logic signed [tsf_pkg::WideW-1:0]    quotient_o
);

  localparam int unsigned W    = tsf_pkg::WideW;
  localparam int unsigned CntW = $clog2(W);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    rem_q, quo_q, dvs_q;
  logic            neg_q;

  logic [W:0] shifted;
  logic [W:0] diff;
  logic       ge;

  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == CntW'(W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // magnitudes; the most negative dividend maps to 2^63 unsigned
      quo_q <= dividend_i[W-1] ? W'(-dividend_i) : W'(dividend_i);
      dvs_q <= divisor_i[W-1] ? W'(-divisor_i) : W'(divisor_i);
      neg_q <= dividend_i[W-1] ^ divisor_i[W-1];
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[W-1:0] : shifted[W-1:0];
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

// File: rtl/core/tsf_datapath.sv
// ----------------------------------------------------------------------------
// tsf_datapath
// Weight registers, filter state, working registers, shared divider and
// result register of the trend smoothing filter.
// ----------------------------------------------------------------------------
module tsf_datapath #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tsf_pkg::cmd_t                        cmd_i,
  output tsf_pkg::status_t                     status_o,
  input  logic [tsf_pkg::PriceW-1:0]           price_i,
  input  logic                                 series_start_i,
  input  logic                                 cfg_valid_i,
  input  logic [tsf_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [tsf_pkg::WeightW-1:0]          cfg_data_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic signed [tsf_pkg::FieldW-1:0]    level_o,
  output logic signed [tsf_pkg::FieldW-1:0]    slope_o,
  output logic signed [tsf_pkg::FieldW-1:0]    smoothed_slope_o,
  output logic signed [tsf_pkg::FieldW-1:0]    ratio_o,
  output logic                                 bad_config_o
);

  localparam int unsigned W  = tsf_pkg::WideW;
  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned FW = tsf_pkg::FieldW;
  localparam int unsigned SW = tsf_pkg::SumW;
  localparam logic signed [W-1:0] VMax = $signed((64'd1 << (VW - 1)) - 64'd1);
  localparam logic signed [W-1:0] VMin = ~VMax;

  function automatic logic signed [VW-1:0] clampv(input logic signed [W-1:0] v);
    logic signed [W-1:0] r;
    r = (v > VMax) ? VMax : ((v < VMin) ? VMin : v);
    return r[VW-1:0];
  endfunction

  logic [tsf_pkg::WeightW-1:0] weight_q [tsf_pkg::RegCount];

  logic signed [VW-1:0] ll_q, lbl_q, sl_q, sbl_q;
  logic [1:0]           idx_q;
  logic                 out_valid_q;

  logic signed [W-1:0]  x_q, p1_q, p2_q, e_q, t_q, u_q;
  logic signed [VW-1:0] y_q, level_q, slope_q, ss_q, ratio_q;
  logic                 start_q, stage_q, bad_q;
  logic signed [FW-1:0] out_level_q, out_slope_q, out_ss_q, out_ratio_q;
  logic                 out_bad_q;

  logic [tsf_pkg::WeightW-1:0] wa, wb, wc, wd;
  logic [SW-1:0]               sum_ab, sum_cd;
  logic signed [VW-1:0]        slope_next;
  logic                        ratio_direct, out_free, commit;
  logic                        div_start, div_done;
  logic signed [W-1:0]         div_num, div_den, quot;
  logic signed [W-1:0]         lvl_ext, slp_ext, ss_ext, rat_ext;

  // weights of the stage in work
  assign wa = stage_q ? weight_q[tsf_pkg::RegSlopeInput] : weight_q[tsf_pkg::RegLevelInput];
  assign wb = stage_q ? weight_q[tsf_pkg::RegSlopeHist]  : weight_q[tsf_pkg::RegLevelHist];
  assign wc = stage_q ? weight_q[tsf_pkg::RegSlopeHold]  : weight_q[tsf_pkg::RegLevelHold];
  assign wd = stage_q ? weight_q[tsf_pkg::RegSlopeTrend] : weight_q[tsf_pkg::RegLevelTrend];
  assign sum_ab = {1'b0, wa} + {1'b0, wb};
  assign sum_cd = {1'b0, wc} + {1'b0, wd};

  assign slope_next   = clampv(tsf_pkg::sat_sub(W'(y_q), W'(ll_q)));
  assign ratio_direct = (ss_q == '0) || (ss_q == '1);
  assign out_free     = !out_valid_q || out_ready_i;
  assign commit       = cmd_i.step == tsf_pkg::CMD_COMMIT;

  assign div_start = (cmd_i.step == tsf_pkg::CMD_TDIV) || (cmd_i.step == tsf_pkg::CMD_UDIV) ||
                     ((cmd_i.step == tsf_pkg::CMD_RATIO) && !ratio_direct);

  always_comb begin
    priority if (cmd_i.step == tsf_pkg::CMD_TDIV) begin
      div_num = t_q;
      div_den = $signed({{(W - SW){1'b0}}, sum_cd});
    end else if (cmd_i.step == tsf_pkg::CMD_UDIV) begin
      div_num = u_q;
      div_den = $signed({{(W - SW){1'b0}}, sum_ab});
    end else begin
      div_num = W'(level_q);
      div_den = W'(ss_q);
    end
  end

  tsf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q    <= tsf_pkg::WeightReset;
      ll_q        <= '0;
      lbl_q       <= '0;
      sl_q        <= '0;
      sbl_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && (cfg_index_i < tsf_pkg::CfgIdxW'(tsf_pkg::RegCount))) begin
        weight_q[cfg_index_i[tsf_pkg::RegIdxW-1:0]] <= cfg_data_i;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
        if (start_q || idx_q == 2'd0) begin
          ll_q  <= level_q;
          lbl_q <= level_q;
          sl_q  <= '0;
          sbl_q <= '0;
          idx_q <= 2'd1;
        end else begin
          lbl_q <= ll_q;
          ll_q  <= level_q;
          sbl_q <= sl_q;
          sl_q  <= ss_q;
          if (idx_q != 2'd3) begin
            idx_q <= idx_q + 2'd1;
          end
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign lvl_ext = W'(level_q);
  assign slp_ext = W'(slope_q);
  assign ss_ext  = W'(ss_q);
  assign rat_ext = W'(ratio_q);

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.step)
      tsf_pkg::CMD_LOAD: begin
        x_q     <= W'(clampv($signed({{(W - tsf_pkg::PriceW){1'b0}}, price_i})));
        start_q <= series_start_i;
        bad_q   <= 1'b0;
        stage_q <= 1'b0;
      end
      tsf_pkg::CMD_FIRST: begin
        level_q <= x_q[VW-1:0];
        slope_q <= '0;
        ss_q    <= '0;
        ratio_q <= clampv(tsf_pkg::NoSlopeRatio);
      end
      tsf_pkg::CMD_LSETUP: begin
        stage_q <= 1'b0;
        p1_q    <= W'(ll_q);
        p2_q    <= (idx_q >= 2'd2) ? W'(lbl_q) : W'(ll_q);
      end
      tsf_pkg::CMD_SSETUP: begin
        stage_q <= 1'b1;
        x_q     <= W'(slope_q);
        p1_q    <= W'(sl_q);
        p2_q    <= (idx_q == 2'd3) ? W'(sbl_q) : W'(sl_q);
      end
      tsf_pkg::CMD_BYPASS: begin
        y_q   <= x_q[VW-1:0];
        bad_q <= 1'b1;
      end
      tsf_pkg::CMD_E1: e_q <= tsf_pkg::sat_mul(p1_q, tsf_pkg::TrendGain);
      tsf_pkg::CMD_E2: e_q <= tsf_pkg::sat_sub(e_q, p2_q);
      tsf_pkg::CMD_E3: e_q <= tsf_pkg::sat_mul(e_q, {1'b0, wd});
      tsf_pkg::CMD_T1: t_q <= tsf_pkg::sat_mul(p1_q, {1'b0, wc});
      tsf_pkg::CMD_T2: t_q <= tsf_pkg::sat_add(t_q, e_q);
      tsf_pkg::CMD_T3: t_q <= tsf_pkg::sat_mul(t_q, {1'b0, wb});
      tsf_pkg::CMD_TQ: t_q <= quot;
      tsf_pkg::CMD_U1: u_q <= tsf_pkg::sat_mul(x_q, {1'b0, wa});
      tsf_pkg::CMD_U2: u_q <= tsf_pkg::sat_add(u_q, t_q);
      tsf_pkg::CMD_UQ: y_q <= clampv(quot);
      tsf_pkg::CMD_STAGE_DONE: begin
        if (!stage_q) begin
          level_q <= y_q;
          slope_q <= slope_next;
          // second sample: smoothed slope is the raw slope
          if (idx_q == 2'd1) begin
            ss_q <= slope_next;
          end
        end else begin
          ss_q <= y_q;
        end
      end
      tsf_pkg::CMD_RATIO: begin
        if (ss_q == '0) begin
          ratio_q <= clampv(tsf_pkg::NoSlopeRatio);
        end else if (ss_q == '1) begin
          ratio_q <= clampv(tsf_pkg::sat_sub('0, lvl_ext));
        end
      end
      tsf_pkg::CMD_RQ: ratio_q <= clampv(quot);
      tsf_pkg::CMD_COMMIT: begin
        out_level_q <= lvl_ext[FW-1:0];
        out_slope_q <= slp_ext[FW-1:0];
        out_ss_q    <= ss_ext[FW-1:0];
        out_ratio_q <= rat_ext[FW-1:0];
        out_bad_q   <= bad_q;
      end
      default: ;
    endcase
  end

  assign status_o.first        = start_q || (idx_q == 2'd0);
  assign status_o.stage_bad    = (sum_ab == '0) || (sum_cd == '0);
  assign status_o.stage_slope  = stage_q;
  assign status_o.skip_slope   = idx_q == 2'd1;
  assign status_o.ratio_direct = ratio_direct;
  assign status_o.div_done     = div_done;
  assign status_o.out_free     = out_free;

  assign out_valid_o      = out_valid_q;
  assign level_o          = out_level_q;
  assign slope_o          = out_slope_q;
  assign smoothed_slope_o = out_ss_q;
  assign ratio_o          = out_ratio_q;
  assign bad_config_o     = out_bad_q;

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> out_free)
    else $error("result register overwritten");

  // after a commit the sample count is never zero
  a_idx_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> idx_q != 2'd0)
    else $error("sample count not advanced");

  // a stage bypass always flags the configuration
  a_bypass_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step == tsf_pkg::CMD_BYPASS |=> bad_q)
    else $error("bypass without bad config flag");

endmodule

// File: rtl/core/tsf_ctrl.sv
// ----------------------------------------------------------------------------
// tsf_ctrl
// Sequencer stepping the datapath through both smoothing stages and the
// ratio division.
// ----------------------------------------------------------------------------
module tsf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tsf_pkg::status_t  status_i,
  output tsf_pkg::cmd_t     cmd_o
);

  typedef enum logic [19:0] {
    ST_IDLE   = 20'h00001,
    ST_DECIDE = 20'h00002,
    ST_SSETUP = 20'h00004,
    ST_CHECK  = 20'h00008,
    ST_E1     = 20'h00010,
    ST_E2     = 20'h00020,
    ST_E3     = 20'h00040,
    ST_T1     = 20'h00080,
    ST_T2     = 20'h00100,
    ST_T3     = 20'h00200,
    ST_TDIV   = 20'h00400,
    ST_TWAIT  = 20'h00800,
    ST_U1     = 20'h01000,
    ST_U2     = 20'h02000,
    ST_UDIV   = 20'h04000,
    ST_UWAIT  = 20'h08000,
    ST_DONE   = 20'h10000,
    ST_RATIO  = 20'h20000,
    ST_RWAIT  = 20'h40000,
    ST_COMMIT = 20'h80000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.step = tsf_pkg::CMD_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.step = tsf_pkg::CMD_LOAD;
          state_d    = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status_i.first) begin
          cmd_o.step = tsf_pkg::CMD_FIRST;
          state_d    = ST_COMMIT;
        end else begin
          cmd_o.step = tsf_pkg::CMD_LSETUP;
          state_d    = ST_CHECK;
        end
      end
      ST_SSETUP: begin
        cmd_o.step = tsf_pkg::CMD_SSETUP;
        state_d    = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.stage_bad) begin
          cmd_o.step = tsf_pkg::CMD_BYPASS;
          state_d    = ST_DONE;
        end else begin
          state_d = ST_E1;
        end
      end
      ST_E1: begin cmd_o.step = tsf_pkg::CMD_E1; state_d = ST_E2; end
      ST_E2: begin cmd_o.step = tsf_pkg::CMD_E2; state_d = ST_E3; end
      ST_E3: begin cmd_o.step = tsf_pkg::CMD_E3; state_d = ST_T1; end
      ST_T1: begin cmd_o.step = tsf_pkg::CMD_T1; state_d = ST_T2; end
      ST_T2: begin cmd_o.step = tsf_pkg::CMD_T2; state_d = ST_T3; end
      ST_T3: begin cmd_o.step = tsf_pkg::CMD_T3; state_d = ST_TDIV; end
      ST_TDIV: begin cmd_o.step = tsf_pkg::CMD_TDIV; state_d = ST_TWAIT; end
      ST_TWAIT: begin
        if (status_i.div_done) begin
          cmd_o.step = tsf_pkg::CMD_TQ;
          state_d    = ST_U1;
        end
      end
      ST_U1: begin cmd_o.step = tsf_pkg::CMD_U1; state_d = ST_U2; end
      ST_U2: begin cmd_o.step = tsf_pkg::CMD_U2; state_d = ST_UDIV; end
      ST_UDIV: begin cmd_o.step = tsf_pkg::CMD_UDIV; state_d = ST_UWAIT; end
      ST_UWAIT: begin
        if (status_i.div_done) begin
          cmd_o.step = tsf_pkg::CMD_UQ;
          state_d    = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd_o.step = tsf_pkg::CMD_STAGE_DONE;
        // slope stage is skipped on the second sample
        if (status_i.stage_slope || status_i.skip_slope) begin
          state_d = ST_RATIO;
        end else begin
          state_d = ST_SSETUP;
        end
      end
      ST_RATIO: begin
        cmd_o.step = tsf_pkg::CMD_RATIO;
        state_d    = status_i.ratio_direct ? ST_COMMIT : ST_RWAIT;
      end
      ST_RWAIT: begin
        if (status_i.div_done) begin
          cmd_o.step = tsf_pkg::CMD_RQ;
          state_d    = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (status_i.out_free) begin
          cmd_o.step = tsf_pkg::CMD_COMMIT;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/trend_smoothing_filter.sv
// ----------------------------------------------------------------------------
// trend_smoothing_filter
// Two-stage trend-extrapolating exponential smoother for a price series.
// ----------------------------------------------------------------------------
// division: none for the first sample of a series; later samples take up to
//   five runs of the shared serial divider, fewer on the second sample, on a
//   bypassed stage or with a direct ratio
// throughput: one sample at a time; the next sample is taken once the result
//   is in the output register, which waits there while the sink stalls
// reset: weights return to defaults, filter history and sample count clear
module trend_smoothing_filter #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tsf_sample_if.sink            sample_i,
  tsf_result_if.source          result_o,
  tsf_cfg_if.sink               cfg_i
);

  tsf_pkg::cmd_t    cmd;
  tsf_pkg::status_t status;

  assign cfg_i.ready = 1'b1;

  tsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tsf_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .price_i          (sample_i.price),
    .series_start_i   (sample_i.series_start),
    .cfg_valid_i      (cfg_i.valid),
    .cfg_index_i      (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .out_ready_i      (result_o.ready),
    .out_valid_o      (result_o.valid),
    .level_o          (result_o.level),
    .slope_o          (result_o.slope),
    .smoothed_slope_o (result_o.smoothed_slope),
    .ratio_o          (result_o.ratio),
    .bad_config_o     (result_o.bad_config)
  );

endmodule
